// ----- src/brpa_pkg.sv -----
// Package for the box radiation pressure accumulator: sizes, register codes, payload types.
`timescale 1ns / 1ps
package brpa_pkg;
  localparam int unsigned COEF_BITS_DEF = 21;
  localparam int unsigned ACC_BITS_DEF  = 48;
  localparam int unsigned REG_BITS      = 63;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned VEC_BITS      = 16;
  localparam int unsigned MAG_BITS      = 20;
  localparam int unsigned OUT_BITS      = 48;
  // Serial multiplier operand widths: multiplicand signed, multiplier signed.
  localparam int unsigned MA_BITS       = 48;
  localparam int unsigned MB_BITS       = 24;
  localparam int unsigned PROD_BITS     = MA_BITS + MB_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRONT_SF = 3'd0,
    REG_FRONT_SN = 3'd1,
    REG_FRONT_DF = 3'd2,
    REG_BACK_SF  = 3'd3,
    REG_BACK_SN  = 3'd4,
    REG_BACK_DF  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic               last_flux;
    logic [47:0]        axis_three;
    logic [47:0]        axis_two;
    logic [47:0]        axis_one;
    logic [MAG_BITS-1:0] mag_long;
    logic [MAG_BITS-1:0] mag_short;
    logic signed [VEC_BITS-1:0] dir_z;
    logic signed [VEC_BITS-1:0] dir_y;
    logic signed [VEC_BITS-1:0] dir_x;
  } flux_in_t;

  typedef struct packed {
    logic                       saturated;
    logic signed [OUT_BITS-1:0] accel_z;
    logic signed [OUT_BITS-1:0] accel_y;
    logic signed [OUT_BITS-1:0] accel_x;
  } accel_out_t;

  // Control between the sequencer and the serial multiplier.
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } mul_ctl_t;

  function automatic logic signed [MA_BITS-1:0] round14(input logic signed [PROD_BITS-1:0] v);
    logic signed [PROD_BITS-1:0] y;
    y = v + PROD_BITS'(8192);
    return MA_BITS'(y >>> 14);
  endfunction
endpackage

// ----- src/brpa_mul.sv -----
// Radix-2 shift-and-add signed multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module brpa_mul (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [brpa_pkg::MA_BITS-1:0] a,
  input  logic signed [brpa_pkg::MB_BITS-1:0] b,
  output logic busy,
  output logic done,
  output logic signed [brpa_pkg::PROD_BITS-1:0] prod
);
  import brpa_pkg::*;
  localparam int unsigned CNT_BITS = $clog2(MB_BITS + 1);

  logic signed [PROD_BITS-1:0] mcand;
  logic [MB_BITS-1:0]          mplier;
  logic [CNT_BITS-1:0]         cnt;
  logic signed [PROD_BITS-1:0] addend;

  // The top multiplier bit carries negative weight.
  always_comb begin
    addend = mplier[0] ? mcand : '0;
    if (cnt == CNT_BITS'(1)) addend = -addend;
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy   <= 1'b1;
      cnt    <= CNT_BITS'(MB_BITS);
      mcand  <= PROD_BITS'(a);
      mplier <= b;
      prod   <= '0;
    end else if (busy) begin
      prod   <= prod + addend;
      mcand  <= mcand <<< 1;
      mplier <= mplier >> 1;
      cnt    <= cnt - CNT_BITS'(1);
      if (cnt == CNT_BITS'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst) assert (!(done && busy)) else $error("mul done while busy");
  end
  property p_start_busy; @(posedge clk) disable iff (rst) start |=> busy; endproperty
  assert property (p_start_busy) else $error("mul did not start");
  property p_done_pulse; @(posedge clk) disable iff (rst) done |=> !done; endproperty
  assert property (p_done_pulse) else $error("done longer than a cycle");
endmodule

// ----- src/brpa_seq.sv -----
// Sequencer: walks the multiply program for one flux and keeps the accumulator.
`timescale 1ns / 1ps
module brpa_seq #(
  parameter int unsigned COEF_BITS = brpa_pkg::COEF_BITS_DEF,
  parameter int unsigned ACC_BITS  = brpa_pkg::ACC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic go,
  input  brpa_pkg::flux_in_t item,
  input  logic [brpa_pkg::REG_BITS-1:0] regs [6],
  output brpa_pkg::mul_ctl_t mctl,
  input  logic mul_busy,
  input  logic mul_done,
  input  logic signed [brpa_pkg::PROD_BITS-1:0] prod,
  output logic signed [brpa_pkg::MA_BITS-1:0] ma,
  output logic signed [brpa_pkg::MB_BITS-1:0] mb,
  output logic fin,
  output logic emit,
  output brpa_pkg::accel_out_t result
);
  import brpa_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT} st_t;
  // Program: 0-8 cosine dot products, 9-17 per-axis terms, 18 s round,
  // 19-30 force components, 31-33 scaling by magnitude.
  localparam int unsigned NSTEP = 34;
  localparam int unsigned PC_BITS = $clog2(NSTEP);

  st_t state;
  logic [PC_BITS-1:0] pc;
  logic [1:0] ai, ki;
  logic signed [PROD_BITS-1:0] acc;
  logic signed [MA_BITS-1:0] cos [3];
  logic signed [MA_BITS-1:0] tw [3];
  logic signed [MA_BITS-1:0] fk [3];
  logic back [3];
  logic signed [MA_BITS-1:0] sval;
  logic signed [ACC_BITS-1:0] accum [3];
  logic sat_seen;
  logic signed [PROD_BITS-1:0] acc_next;

  function automatic logic signed [VEC_BITS-1:0] dirc(input flux_in_t f, input logic [1:0] k);
    case (k)
      2'd0: return f.dir_x;
      2'd1: return f.dir_y;
      default: return f.dir_z;
    endcase
  endfunction
  function automatic logic signed [VEC_BITS-1:0] axc(input flux_in_t f, input logic [1:0] i,
                                                    input logic [1:0] k);
    logic [47:0] a;
    case (i)
      2'd0: a = f.axis_one;
      2'd1: a = f.axis_two;
      default: a = f.axis_three;
    endcase
    return a[k*16 +: 16];
  endfunction
  function automatic logic signed [MB_BITS-1:0] coef(input logic [REG_BITS-1:0] r,
                                                   input logic [1:0] k);
    logic signed [COEF_BITS-1:0] c;
    c = r[k*COEF_BITS +: COEF_BITS];
    return MB_BITS'(c);
  endfunction

  // Operand selection for the current step.
  always_comb begin
    ma = '0;
    mb = '0;
    if (pc < PC_BITS'(9)) begin
      ma = MA_BITS'(axc(item, ai, ki));
      mb = MB_BITS'(dirc(item, ki));
    end else if (pc < PC_BITS'(18)) begin
      // three steps per axis: c*sf, sn*c, t*c; t can outgrow the narrow side
      ma = (ki == 2'd2) ? tw[ai] : cos[ai];
      case (ki)
        2'd0: mb = coef(regs[back[ai] ? REG_BACK_SF : REG_FRONT_SF], ai);
        2'd1: mb = coef(regs[back[ai] ? REG_BACK_SN : REG_FRONT_SN], ai);
        default: mb = MB_BITS'(cos[ai]);
      endcase
    end else if (pc < PC_BITS'(31)) begin
      // per component k: s*dir_k then w_i*axis_i_k
      mb = MB_BITS'(ki == 2'd3 ? dirc(item, ai) : axc(item, ki, ai));
      ma = (ki == 2'd3) ? sval : tw[ki];
    end else begin
      ma = fk[ai];
      mb = MB_BITS'({1'b0, item.mag_short} + {1'b0, item.mag_long});
    end
  end

  assign acc_next = acc + prod;
  assign mctl.start = (state == S_ISSUE) && pc != PC_BITS'(18);
  assign mctl.busy  = mul_busy;
  assign mctl.done  = mul_done;

  localparam logic signed [ACC_BITS-1:0] AMAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] AMIN = {1'b1, {(ACC_BITS-1){1'b0}}};

  always_ff @(posedge clk) begin
    logic signed [PROD_BITS:0] sum;
    logic signed [PROD_BITS-1:0] dlt;
    logic signed [MA_BITS-1:0] t;
    fin  <= 1'b0;
    emit <= 1'b0;
    if (rst) begin
      state    <= S_IDLE;
      pc       <= '0;
      sat_seen <= 1'b0;
      for (int n = 0; n < 3; n++) accum[n] <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (go) begin
          state <= S_ISSUE;
          pc <= '0; ai <= 2'd0; ki <= 2'd0; acc <= '0; sval <= '0;
        end
        S_ISSUE: begin
          if (pc == PC_BITS'(18)) begin
            sval <= round14(acc);
            acc <= '0;
            pc <= pc + PC_BITS'(1);
            ai <= 2'd0; ki <= 2'd3;
          end else state <= S_WAIT;
        end
        S_WAIT: if (mul_done) begin
          state <= S_ISSUE;
          pc <= pc + PC_BITS'(1);
          if (pc < PC_BITS'(9)) begin
            if (ki == 2'd2) begin
              cos[ai]  <= round14(-acc_next);
              back[ai] <= acc_next > 0;
              acc <= '0; ki <= 2'd0; ai <= ai + 2'd1;
            end else begin
              acc <= acc_next; ki <= ki + 2'd1;
            end
            if (pc == PC_BITS'(8)) ai <= 2'd0;
          end else if (pc < PC_BITS'(18)) begin
            case (ki)
              2'd0: begin sval <= sval + MA_BITS'(prod); ki <= 2'd1; end
              2'd1: begin
                t = round14(prod) +
                    MA_BITS'(coef(regs[back[ai] ? REG_BACK_DF : REG_FRONT_DF], ai));
                tw[ai] <= t; ki <= 2'd2;
              end
              default: begin
                tw[ai] <= round14(prod); ki <= 2'd0; ai <= ai + 2'd1;
              end
            endcase
            if (pc == PC_BITS'(17)) begin
              acc <= PROD_BITS'(sval); ai <= 2'd0;
            end
          end else if (pc < PC_BITS'(31)) begin
            if (ki == 2'd2) begin
              fk[ai] <= round14(acc_next); acc <= '0; ki <= 2'd3; ai <= ai + 2'd1;
            end else begin
              acc <= acc_next; ki <= (ki == 2'd3) ? 2'd0 : ki + 2'd1;
            end
            if (pc == PC_BITS'(30)) begin ai <= 2'd0; ki <= 2'd0; end
          end else begin
            dlt = prod;
            sum = (PROD_BITS+1)'(accum[ai]) + (PROD_BITS+1)'(dlt);
            if (sum > (PROD_BITS+1)'(AMAX)) begin
              accum[ai] <= AMAX; sat_seen <= 1'b1;
            end else if (sum < (PROD_BITS+1)'(AMIN)) begin
              accum[ai] <= AMIN; sat_seen <= 1'b1;
            end else accum[ai] <= ACC_BITS'(sum);
            ai <= ai + 2'd1;
            if (pc == PC_BITS'(NSTEP-1)) begin
              state <= S_IDLE;
              fin <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (fin && item.last_flux) begin
        emit <= 1'b1;
        result.accel_x <= OUT_BITS'(accum[0]);
        result.accel_y <= OUT_BITS'(accum[1]);
        result.accel_z <= OUT_BITS'(accum[2]);
        result.saturated <= sat_seen;
        sat_seen <= 1'b0;
        for (int n = 0; n < 3; n++) accum[n] <= '0;
      end
    end
  end

  property p_go_idle; @(posedge clk) disable iff (rst) go |-> state == S_IDLE; endproperty
  assert property (p_go_idle) else $error("item taken while busy");
  property p_fin_idle; @(posedge clk) disable iff (rst) fin |-> state == S_IDLE; endproperty
  assert property (p_fin_idle) else $error("finish outside idle");
  property p_wait_busy; @(posedge clk) disable iff (rst)
    (state == S_WAIT && !mul_done) |-> mul_busy || $past(mctl.start); endproperty
  assert property (p_wait_busy) else $error("waiting on idle multiplier");
endmodule

// ----- src/box_radiation_pressure_accum_unit.sv -----
// Top level of the box radiation pressure accumulator.
`timescale 1ns / 1ps
// Each flux runs 33 multiplies on one shared radix-2 multiplier that retires
// one bit of its 24-bit multiplier operand per cycle. Each multiply is issued
// in the issue state and collected in the wait state, and one more step rounds
// the specular sum; the serial multiplier sets how long a flux occupies the
// block. Flux transfers are taken one at a time. The result of a flux marked
// last is registered, after its arithmetic ends, first into the sequencer's
// result register and then into the output register, and the next flux
// transfer is taken while it waits there. If a new sum is ready while an
// earlier one still waits in the output register, the new sum is held inside
// and the next flux transfer waits until it has moved out. Coefficient registers
// are to be written by the user only while the block is idle; the block itself
// does not enforce this.
module box_radiation_pressure_accum_unit #(
  parameter int unsigned COEF_BITS = brpa_pkg::COEF_BITS_DEF,
  parameter int unsigned ACC_BITS  = brpa_pkg::ACC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  brpa_pkg::flux_in_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output brpa_pkg::accel_out_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [brpa_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [brpa_pkg::REG_BITS-1:0] cfg_data
);
  import brpa_pkg::*;

  logic [REG_BITS-1:0] regs [6];
  flux_in_t item;
  logic busy, fin, emit, go;
  logic hold, move;
  mul_ctl_t mctl;
  logic mbusy, mdone;
  logic signed [PROD_BITS-1:0] prod;
  logic signed [MA_BITS-1:0] ma;
  logic signed [MB_BITS-1:0] mb;
  accel_out_t result;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy;
  assign go        = in_valid && in_ready;
  // A finished sum moves to the output register as soon as that register is free.
  assign move      = (emit || hold) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < 6; n++) regs[n] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRONT_SF, REG_FRONT_SN, REG_FRONT_DF,
        REG_BACK_SF, REG_BACK_SN, REG_BACK_DF: regs[cfg_index] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      hold <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (go) begin busy <= 1'b1; item <= in_data; end
      else if (move || (fin && !item.last_flux)) busy <= 1'b0;
      if (move) hold <= 1'b0;
      else if (emit) hold <= 1'b1;
      if (move) begin out_valid <= 1'b1; out_data <= result; end
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  brpa_seq #(.COEF_BITS(COEF_BITS), .ACC_BITS(ACC_BITS)) u_seq (
    .clk, .rst, .go, .item, .regs, .mctl, .mul_busy(mbusy), .mul_done(mdone),
    .prod, .ma, .mb, .fin, .emit, .result
  );

  brpa_mul u_mul (
    .clk, .rst, .start(mctl.start), .a(ma), .b(mb), .busy(mbusy), .done(mdone), .prod
  );

  property p_no_go_busy; @(posedge clk) disable iff (rst) go |=> busy; endproperty
  assert property (p_no_go_busy) else $error("flux lost");
  property p_emit_free; @(posedge clk) disable iff (rst) emit |-> !hold; endproperty
  assert property (p_emit_free) else $error("result overwritten");
  property p_hold; @(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_data); endproperty
  assert property (p_hold) else $error("result dropped");
endmodule

// ----- sim/box_radiation_pressure_accum_unit_tb.sv -----
// Self-checking testbench for the box radiation pressure accumulator top level.
`timescale 1ns / 1ps
module box_radiation_pressure_accum_unit_tb;
  import brpa_pkg::*;

  // Register indexes past the last coefficient register; writes to them must be dropped.
  localparam logic [CFG_IDX_BITS-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] IDX_SPARE_HI = 3'd7;
  localparam int CF = COEF_BITS_DEF;
  localparam longint ACC_HI = (64'sd1 <<< (ACC_BITS_DEF - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;
  // Time one flux may hold the block, with margin on top.
  localparam int FLUX_CYCLES = 1200;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  flux_in_t in_data;
  accel_out_t out_data;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [REG_BITS-1:0] cfg_data;

  box_radiation_pressure_accum_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the block's state: coefficient registers, running sums and sticky clamp flag.
  logic [REG_BITS-1:0] coef_shadow [6];
  longint accel_sum [3];
  bit clamp_seen;

  flux_in_t flux_pending[$];
  accel_out_t accel_expected[$];
  int errors = 0;
  int fluxes_sent = 0;
  int sums_checked = 0;
  int sat_sums = 0;
  longint cycles = 0;

  function automatic longint coef_of(int r, int k);
    logic signed [CF-1:0] v;
    v = coef_shadow[r][k*CF +: CF];
    return longint'(v);
  endfunction

  // Round half up to Q14: arithmetic shift of a signed value floors.
  function automatic longint rnd14(longint v);
    return (v + 64'sd8192) >>> 14;
  endfunction

  // Fold one accepted flux into the shadow sums; on the last flux queue the expected sum.
  function automatic void fold_flux(flux_in_t f);
    longint dir [3];
    longint ax [3][3];
    longint cosv [3];
    longint wt [3];
    longint spec, raw, t, v, fk, mag, d;
    logic [47:0] axes [3];
    logic signed [15:0] comp;
    int base;
    accel_out_t res;
    dir[0] = longint'(f.dir_x);
    dir[1] = longint'(f.dir_y);
    dir[2] = longint'(f.dir_z);
    mag = longint'(f.mag_short) + longint'(f.mag_long);
    axes[0] = f.axis_one;
    axes[1] = f.axis_two;
    axes[2] = f.axis_three;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        comp = axes[i][16*k +: 16];
        ax[i][k] = longint'(comp);
      end
    end
    spec = 0;
    for (int i = 0; i < 3; i++) begin
      raw = 0;
      for (int k = 0; k < 3; k++) raw += ax[i][k] * dir[k];
      raw = -raw;
      // A negative cosine picks the back face; zero counts as front.
      base = (raw < 0) ? int'(REG_BACK_SF) : int'(REG_FRONT_SF);
      cosv[i] = rnd14(raw);
      spec += cosv[i] * coef_of(base, i);
      t = rnd14(coef_of(base + 1, i) * cosv[i]) + coef_of(base + 2, i);
      wt[i] = rnd14(t * cosv[i]);
    end
    spec = rnd14(spec);
    for (int k = 0; k < 3; k++) begin
      v = spec * dir[k];
      for (int i = 0; i < 3; i++) v += wt[i] * ax[i][k];
      fk = rnd14(v);
      d = fk * mag;
      if (d > 0 && accel_sum[k] > ACC_HI - d) begin
        accel_sum[k] = ACC_HI;
        clamp_seen = 1'b1;
      end else if (d < 0 && accel_sum[k] < ACC_LO - d) begin
        accel_sum[k] = ACC_LO;
        clamp_seen = 1'b1;
      end else begin
        accel_sum[k] = accel_sum[k] + d;
      end
    end
    if (f.last_flux) begin
      res.accel_x = accel_sum[0][47:0];
      res.accel_y = accel_sum[1][47:0];
      res.accel_z = accel_sum[2][47:0];
      res.saturated = clamp_seen;
      accel_expected.insert(accel_expected.size(), res);
      for (int k = 0; k < 3; k++) accel_sum[k] = 0;
      clamp_seen = 1'b0;
    end
  endfunction

  // Most gaps are short, a few are long, and now and then a stretch runs with none.
  function automatic int pick_gap(bit burst);
    if (burst) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
    return $urandom_range(10, 80);
  endfunction

  // Flux driver: presents queued fluxes and predicts each one at its transfer.
  int in_gap = 0;
  bit in_burst = 1'b0;
  always @(posedge clk) begin
    bit nv;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        fold_flux(in_data);
        fluxes_sent++;
        nv = 1'b0;
      end
      if ($urandom_range(0, 99) == 0) in_burst = !in_burst;
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (flux_pending.size() > 0) begin
          nv = 1'b1;
          in_data <= flux_pending.pop_front();
          in_gap = pick_gap(in_burst);
        end
      end
      in_valid <= nv;
    end
  end

  // Result monitor: random back-pressure, and each transfer checked against the oldest sum.
  int out_stall = 0;
  bit out_burst = 1'b0;
  always @(posedge clk) begin
    accel_out_t exp_sum;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (accel_expected.size() == 0) begin
          $display("%0t: result with nothing expected: %h", $time, out_data);
          errors++;
        end else begin
          exp_sum = accel_expected.pop_front();
          sums_checked++;
          if (exp_sum.saturated) sat_sums++;
          if (out_data.accel_x !== exp_sum.accel_x) begin
            $display("%0t: accel_x expected %h actual %h", $time, exp_sum.accel_x,
                     out_data.accel_x);
            errors++;
          end
          if (out_data.accel_y !== exp_sum.accel_y) begin
            $display("%0t: accel_y expected %h actual %h", $time, exp_sum.accel_y,
                     out_data.accel_y);
            errors++;
          end
          if (out_data.accel_z !== exp_sum.accel_z) begin
            $display("%0t: accel_z expected %h actual %h", $time, exp_sum.accel_z,
                     out_data.accel_z);
            errors++;
          end
          if (out_data.saturated !== exp_sum.saturated) begin
            $display("%0t: saturated expected %b actual %b", $time, exp_sum.saturated,
                     out_data.saturated);
            errors++;
          end
        end
      end
      if ($urandom_range(0, 99) == 0) out_burst = !out_burst;
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!out_burst && $urandom_range(0, 3) == 0) out_stall = pick_gap(1'b0);
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // One register write over the configuration channel; out-of-range indexes change nothing.
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [REG_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= REG_BACK_DF) coef_shadow[idx] = val;
    cfg_valid <= 1'b0;
  endtask

  // Wait until every flux has transferred and every sum has come back, then let the
  // block finish any flux whose sum is not yet due.
  task automatic drain();
    do @(posedge clk);
    while (flux_pending.size() > 0 || in_valid || accel_expected.size() > 0);
    repeat (FLUX_CYCLES) @(posedge clk);
  endtask

  function automatic logic [47:0] axis_pack(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    return {z, y, x};
  endfunction

  // Append one flux to the driver's queue.
  function automatic void add_flux(flux_in_t fl);
    flux_pending.insert(flux_pending.size(), fl);
  endfunction

  // Random flux; a quarter keep fully random vectors, the rest get direction and first-axis components within +-16384.
  function automatic flux_in_t rand_flux(bit last, int mag_max);
    flux_in_t f;
    f = $bits(flux_in_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom});
    if ($urandom_range(0, 3) != 0) begin
      f.dir_x = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
      f.dir_y = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
      f.dir_z = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
      f.axis_one = axis_pack(16'($urandom_range(0, 32768) - 16384),
                             16'($urandom_range(0, 32768) - 16384),
                             16'($urandom_range(0, 32768) - 16384));
    end
    f.mag_short = 20'($urandom_range(0, mag_max));
    f.mag_long = 20'($urandom_range(0, mag_max));
    f.last_flux = last;
    return f;
  endfunction

  function automatic logic [REG_BITS-1:0] rand_reg(int bits);
    logic [REG_BITS-1:0] r;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      r[k*CF +: CF] = CF'($signed(CF'($urandom)) >>> (CF - bits));
    end
    r[REG_BITS-1] = 1'($urandom);
    return r;
  endfunction

  // Queue random lists of fluxes, each list closed by a last flux.
  task automatic queue_lists(int count, int mag_max);
    int left;
    left = count;
    while (left > 0) begin
      int len;
      len = $urandom_range(1, 8);
      if (len > left) len = left;
      for (int j = 0; j < len; j++) add_flux(rand_flux(j == len - 1, mag_max));
      left -= len;
    end
  endtask

  flux_in_t f;
  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    out_ready <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    for (int r = 0; r < 6; r++) coef_shadow[r] = '0;
    for (int k = 0; k < 3; k++) accel_sum[k] = 0;
    clamp_seen = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part with reset coefficients: everything must sum to zero.
    f = '0;
    f.dir_x = 16'sh7fff;
    f.mag_short = '1;
    f.axis_one = '1;
    f.last_flux = 1'b1;
    add_flux(f);
    drain();

    // Largest coefficients: front most positive, back most negative.
    for (int r = 0; r < 3; r++) write_reg(reg_idx_t'(r), {3{1'b0, {(CF-1){1'b1}}}});
    for (int r = 3; r < 6; r++) write_reg(reg_idx_t'(r), {3{1'b1, {(CF-1){1'b0}}}});
    // Writes past the last register must leave the coefficients alone.
    write_reg(IDX_SPARE_LO, '1);
    write_reg(IDX_SPARE_HI, '0);
    f = '0;
    add_flux(f);                                                   // all zero
    f.dir_x = 16'sh4000; f.axis_one = axis_pack(16'h4000, 16'h0, 16'h0);   // back face
    f.mag_short = 20'd16; add_flux(f);
    f.dir_x = -16'sh4000; f.last_flux = 1'b1;                      // front face
    add_flux(f);
    f = '0;                                                        // zero cosine
    f.dir_y = 16'sh4000; f.axis_one = axis_pack(16'h4000, 16'h0, 16'h0);
    f.axis_two = axis_pack(16'h0, 16'h0, 16'h4000);
    f.axis_three = axis_pack(16'h4000, 16'h0, 16'h0);
    f.mag_long = '1; add_flux(f);
    f.last_flux = 1'b1; add_flux(f);
    // Extreme vectors and magnitudes: these clamp the sums.
    f.dir_x = 16'sh7fff; f.dir_y = -16'sh8000; f.dir_z = 16'sh7fff;
    f.axis_one = axis_pack(16'h8000, 16'h8000, 16'h8000);
    f.axis_two = axis_pack(16'h7fff, 16'h7fff, 16'h7fff);
    f.axis_three = '1; f.mag_short = '1; f.mag_long = '1; f.last_flux = 1'b0;
    for (int j = 0; j < 4; j++) add_flux(f);
    f.dir_x = -16'sh8000; f.dir_y = 16'sh7fff; f.dir_z = -16'sh8000; f.last_flux = 1'b1;
    for (int j = 0; j < 4; j++) add_flux(f);
    f.axis_one = '0; f.axis_two = '0; f.axis_three = '0;           // no clamp after clear
    add_flux(f);
    drain();

    // Random phases across several coefficient sizes; phases 0, 3 and 6 use full magnitudes, the rest small ones.
    for (int ph = 0; ph < 8; ph++) begin
      int bits;
      bits = (ph == 0) ? 4 : (ph == 7) ? CF : $urandom_range(6, CF);
      for (int r = 0; r < 6; r++) write_reg(reg_idx_t'(r), rand_reg(bits));
      queue_lists(48, (ph % 3 == 0) ? 20'hfffff : 20'h3ff);
      drain();
    end
    // Back to zero coefficients to close the sweep.
    for (int r = 0; r < 6; r++) write_reg(reg_idx_t'(r), '0);
    queue_lists(8, 20'hfffff);
    drain();

    $display("%0d flux transfers over 11 coefficient settings, %0d sums checked", fluxes_sent,
             sums_checked);
    $display("%0d sums clamped, %0d mismatches", sat_sums, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
